// ===== rtl/core/lpht_pkg.sv =====
// lpht_pkg: shared types and constants for the linear probing hash table
// no dependencies
package lpht_pkg;
  localparam int TableDepth = 32;
  localparam int SlotW = $clog2(TableDepth);
  localparam int SizeW = 6;
  localparam logic [SizeW-1:0] SizeReset = SizeW'(17);

  typedef enum logic [1:0] {OP_ADD = 2'd0, OP_DEL = 2'd1, OP_SEARCH = 2'd2, OP_CLEAR = 2'd3} op_t;
  typedef enum logic [1:0] {ST_OK = 2'd0, ST_EXISTS = 2'd1, ST_FULL = 2'd2, ST_ABSENT = 2'd3} status_t;
  typedef enum logic [1:0] {SL_EMPTY = 2'd0, SL_USED = 2'd1, SL_GONE = 2'd2} slot_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_LOOK, S_FILL, S_READ, S_CLEAR, S_OUT
  } state_t;
endpackage

// ===== rtl/core/lpht_req_if.sv =====
// lpht_req_if: request channel, valid/ready with payload
// depends on nothing
interface lpht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] key;
  logic [63:0] name_lo;
  logic [63:0] name_hi;
  modport source (output valid, op, key, name_lo, name_hi, input ready);
  modport sink (input valid, op, key, name_lo, name_hi, output ready);
endinterface

// ===== rtl/core/lpht_rsp_if.sv =====
// lpht_rsp_if: result channel, valid/ready with payload
// depends on nothing
interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  found_slot;
  logic [63:0] found_name_lo;
  logic [63:0] found_name_hi;
  modport source (output valid, status, found_slot, found_name_lo, found_name_hi, input ready);
  modport sink (input valid, status, found_slot, found_name_lo, found_name_hi, output ready);
endinterface

// ===== rtl/core/linear_probe_hash_table.sv =====
// Linear probing hash table of 32 slots. One request is taken at a time. After reset
// the slot status memory is swept to empty, one slot a cycle, and no item is accepted
// until the sweep ends. The home slot is found by restoring division, one key bit a
// cycle. Then slots are probed one at a time through the slot memory, whose read is
// registered, and an add may take a second scan for a free slot. Search adds a step
// for the name read; clear sweeps all 32 slots. The worst case is an add at 32 slots
// that finds the table full, longer while the result is held off.
// depends on lpht_pkg, lpht_req_if, lpht_rsp_if
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [SizeW-1:0] cfg_wdata,
  lpht_req_if.sink         req,
  lpht_rsp_if.source       rsp
);
  logic [1:0]  stat_mem [TableDepth];
  logic [31:0] key_mem [TableDepth];
  logic [63:0] lo_mem [TableDepth];
  logic [63:0] hi_mem [TableDepth];

  state_t state, state_next;
  logic [SizeW-1:0] table_size;
  logic [1:0] op;
  logic [31:0] key;
  logic [63:0] nlo, nhi;
  logic [SizeW-1:0] n;
  logic [SizeW-1:0] rem;
  logic [4:0] bitc;
  logic [SlotW-1:0] idx, home;
  logic [SizeW:0] cnt;
  logic phase;
  logic sweep_init;
  logic [1:0] rd_stat;
  logic [31:0] rd_key;
  logic [63:0] rd_lo, rd_hi;
  logic [1:0] out_status;
  logic [SlotW-1:0] out_slot;
  logic [63:0] out_lo, out_hi;
  logic [SlotW-1:0] idx_inc;
  logic [SizeW:0] rem_sh;
  logic [SizeW:0] rem_red;
  logic probe_end;
  logic probe_hit;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.status = out_status;
  assign rsp.found_slot = out_slot;
  assign rsp.found_name_lo = out_lo;
  assign rsp.found_name_hi = out_hi;

  assign rem_sh = {rem, key[5'd31 - bitc]};
  assign rem_red = (rem_sh >= {1'b0, n}) ? rem_sh - {1'b0, n} : rem_sh;
  assign idx_inc = (({1'b0, idx} + 6'd1) >= n) ? '0 : idx + 1'b1;
  assign probe_end = (rd_stat == SL_EMPTY) || (cnt == {1'b0, n});
  assign probe_hit = (rd_stat == SL_USED) && (rd_key == key);

  always_ff @(posedge clk) begin
    rd_stat <= stat_mem[idx];
    rd_key <= key_mem[idx];
    rd_lo <= lo_mem[idx];
    rd_hi <= hi_mem[idx];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req.valid) state_next = (op_t'(req.op) == OP_CLEAR) ? S_CLEAR : S_MOD;
      S_MOD:   if (bitc == 5'd31) state_next = S_LOOK;
      S_LOOK: begin
        if (phase) begin
          if (probe_end) state_next = (op_t'(op) == OP_ADD) ? S_FILL : S_OUT;
          else if (probe_hit) state_next = (op_t'(op) == OP_SEARCH) ? S_READ : S_OUT;
        end
      end
      S_FILL:  if (phase && (cnt == {1'b0, n} || rd_stat != SL_USED)) state_next = S_OUT;
      S_READ:  state_next = S_OUT;
      S_CLEAR: if (idx == SlotW'(TableDepth - 1)) state_next = sweep_init ? S_IDLE : S_OUT;
      S_OUT:   if (rsp.ready) state_next = S_IDLE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      table_size <= SizeReset;
      idx <= '0;
      sweep_init <= 1'b1;
    end else begin
      if (cfg_we) table_size <= cfg_wdata;
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op <= req.op;
            key <= req.key;
            nlo <= req.name_lo;
            nhi <= req.name_hi;
            n <= (table_size == '0) ? SizeW'(1) :
                 (table_size > SizeW'(TableDepth)) ? SizeW'(TableDepth) : table_size;
            rem <= '0;
            bitc <= '0;
            idx <= '0;
            out_status <= ST_OK;
            out_slot <= '0;
            out_lo <= '0;
            out_hi <= '0;
          end
        end
        S_MOD: begin
          rem <= SizeW'(rem_red);
          bitc <= bitc + 5'd1;
          if (bitc == 5'd31) begin
            idx <= SlotW'(rem_red);
            home <= SlotW'(rem_red);
            cnt <= '0;
            phase <= 1'b0;
          end
        end
        S_LOOK: begin
          phase <= ~phase;
          if (phase) begin
            if (probe_end) begin
              if (op_t'(op) == OP_ADD) begin
                idx <= home;
                cnt <= '0;
                phase <= 1'b0;
              end else begin
                out_status <= ST_ABSENT;
              end
            end else if (probe_hit) begin
              out_slot <= idx;
              case (op_t'(op))
                OP_ADD: begin
                  out_status <= ST_EXISTS;
                end
                OP_DEL: begin
                  stat_mem[idx] <= SL_GONE;
                end
                default: ;
              endcase
            end else begin
              idx <= idx_inc;
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_FILL: begin
          phase <= ~phase;
          if (phase) begin
            if (cnt == {1'b0, n}) begin
              out_status <= ST_FULL;
            end else if (rd_stat != SL_USED) begin
              stat_mem[idx] <= SL_USED;
              key_mem[idx] <= key;
              lo_mem[idx] <= nlo;
              hi_mem[idx] <= nhi;
              out_slot <= idx;
            end else begin
              idx <= idx_inc;
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_READ: begin
          out_lo <= rd_lo;
          out_hi <= rd_hi;
        end
        S_CLEAR: begin
          stat_mem[idx] <= SL_EMPTY;
          idx <= idx + 1'b1;
          if (idx == SlotW'(TableDepth - 1)) sweep_init <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== dv/tb_linear_probe_hash_table.sv =====
// tb_linear_probe_hash_table: self-checking testbench for the linear probing hash table
// drives requests from a directed table then random traffic, predicts each result in a
// local table model; depends on lpht_pkg, lpht_req_if, lpht_rsp_if and the block
`timescale 1ns / 1ps
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] key;
    logic [63:0] nlo;
    logic [63:0] nhi;
    logic        chk;
    status_t     st;
    logic [4:0]  slot;
  } row_t;

  typedef struct {
    status_t     st;
    logic [4:0]  slot;
    logic [63:0] flo;
    logic [63:0] fhi;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [SizeW-1:0] cfg_wdata = '0;
  lpht_req_if req ();
  lpht_rsp_if rsp ();

  linear_probe_hash_table u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  // local copy of the table
  logic [5:0]  size_reg;
  slot_t       tbl_state [TableDepth];
  logic [31:0] tbl_key [TableDepth];
  logic [63:0] tbl_lo [TableDepth];
  logic [63:0] tbl_hi [TableDepth];
  logic [31:0] stored_keys [$];

  answer_t pending_answers [$];
  int errors = 0;
  int cycles = 0;
  logic hold_rsp = 1'b0;
  int hold_len = 0;
  row_t dir [$];

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int slots_in_use();
    int n;
    n = int'(size_reg);
    if (n == 0) n = 1;
    if (n > TableDepth) n = TableDepth;
    return n;
  endfunction

  function automatic int find_key(logic [31:0] k);
    int n, idx;
    n = slots_in_use();
    idx = k % n;
    for (int i = 0; i < n; i++) begin
      if (tbl_state[idx] == SL_EMPTY) return -1;
      if (tbl_state[idx] == SL_USED && tbl_key[idx] == k) return idx;
      idx = (idx + 1 >= n) ? 0 : idx + 1;
    end
    return -1;
  endfunction

  function automatic answer_t apply_request(op_t op, logic [31:0] k, logic [63:0] lo,
                                            logic [63:0] hi);
    answer_t a;
    int hit, n, idx;
    a = '{ST_OK, 5'd0, 64'd0, 64'd0};
    hit = find_key(k);
    case (op)
      OP_ADD: begin
        if (hit >= 0) begin
          a.st = ST_EXISTS;
          a.slot = 5'(hit);
        end else begin
          n = slots_in_use();
          idx = k % n;
          a.st = ST_FULL;
          for (int i = 0; i < n; i++) begin
            if (tbl_state[idx] != SL_USED) begin
              tbl_state[idx] = SL_USED;
              tbl_key[idx] = k;
              tbl_lo[idx] = lo;
              tbl_hi[idx] = hi;
              a.st = ST_OK;
              a.slot = 5'(idx);
              stored_keys.push_back(k);
              break;
            end
            idx = (idx + 1 >= n) ? 0 : idx + 1;
          end
        end
      end
      OP_DEL: begin
        if (hit >= 0) begin
          tbl_state[hit] = SL_GONE;
          a.slot = 5'(hit);
        end else a.st = ST_ABSENT;
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          a.slot = 5'(hit);
          a.flo = tbl_lo[hit];
          a.fhi = tbl_hi[hit];
        end else a.st = ST_ABSENT;
      end
      default: begin
        for (int i = 0; i < TableDepth; i++) tbl_state[i] = SL_EMPTY;
        stored_keys.delete();
      end
    endcase
    return a;
  endfunction

  // valid drops only when the sender actually pauses
  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_request(row_t r);
    answer_t a;
    idle_gap();
    req.valid <= 1'b1;
    req.op <= r.op;
    req.key <= r.key;
    req.name_lo <= r.nlo;
    req.name_hi <= r.nhi;
    do @(posedge clk); while (!req.ready);
    a = apply_request(r.op, r.key, r.nlo, r.nhi);
    if (r.chk && (a.st != r.st || a.slot != r.slot)) begin
      errors++;
      if (errors <= 10) $display("table row disagrees: op %s key %0d", r.op.name(), r.key);
    end
    pending_answers.push_back(a);
  endtask

  task automatic write_size(logic [5:0] v);
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = v;
  endtask

  task automatic random_request();
    row_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.chk = 1'b0;
    r.nlo = {$urandom, $urandom};
    r.nhi = {$urandom, $urandom};
    if (pick < 2) r.op = OP_CLEAR;
    else if (pick < 45) r.op = OP_ADD;
    else if (pick < 65) r.op = OP_DEL;
    else r.op = OP_SEARCH;
    // other than adds, mostly keys already stored, to reach hits and deep probe chains
    if (stored_keys.size() != 0 && $urandom_range(0, 2) != 0 && r.op != OP_ADD)
      r.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    else if ($urandom_range(0, 9) == 0) r.key = $urandom;
    else r.key = $urandom_range(0, 100);
    send_request(r);
  endtask

  // receiver
  always @(posedge clk) begin
    answer_t e;
    if (rsp.valid && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result, status %0d", rsp.status);
      end else begin
        e = pending_answers.pop_front();
        if (rsp.status !== e.st || rsp.found_slot !== e.slot ||
            rsp.found_name_lo !== e.flo || rsp.found_name_hi !== e.fhi) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d/%0d/%h/%h got %0d/%0d/%h/%h", e.st, e.slot, e.flo,
                     e.fhi, rsp.status, rsp.found_slot, rsp.found_name_lo,
                     rsp.found_name_hi);
        end
      end
    end
  end

  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_rsp = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin
    int waited;
    req.valid = 1'b0;
    req.op = OP_ADD;
    req.key = '0;
    req.name_lo = '0;
    req.name_hi = '0;
    size_reg = SizeReset;
    for (int i = 0; i < TableDepth; i++) begin
      tbl_state[i] = SL_EMPTY;
      tbl_key[i] = '0;
      tbl_lo[i] = '0;
      tbl_hi[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset, size 17
    dir.push_back('{OP_SEARCH, 32'd5, '0, '0, 1'b1, ST_ABSENT, 5'd0});
    dir.push_back('{OP_DEL, 32'd5, '0, '0, 1'b1, ST_ABSENT, 5'd0});
    dir.push_back('{OP_ADD, 32'd0, '0, '0, 1'b1, ST_OK, 5'd0});
    dir.push_back('{OP_ADD, 32'hFFFF_FFFF, '1, '1, 1'b1, ST_OK, 5'd1});
    dir.push_back('{OP_ADD, 32'd17, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                    1'b1, ST_OK, 5'd2});
    dir.push_back('{OP_ADD, 32'd17, '0, '0, 1'b1, ST_EXISTS, 5'd2});
    dir.push_back('{OP_SEARCH, 32'hFFFF_FFFF, '0, '0, 1'b1, ST_OK, 5'd1});
    dir.push_back('{OP_SEARCH, 32'd17, '0, '0, 1'b1, ST_OK, 5'd2});
    dir.push_back('{OP_DEL, 32'd0, '0, '0, 1'b1, ST_OK, 5'd0});
    dir.push_back('{OP_SEARCH, 32'd17, '0, '0, 1'b1, ST_OK, 5'd2});
    dir.push_back('{OP_ADD, 32'd34, 64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA,
                    1'b1, ST_OK, 5'd0});
    dir.push_back('{OP_SEARCH, 32'd34, '0, '0, 1'b0, ST_OK, 5'd0});
    dir.push_back('{OP_CLEAR, 32'd0, '0, '0, 1'b1, ST_OK, 5'd0});
    dir.push_back('{OP_SEARCH, 32'd17, '0, '0, 1'b1, ST_ABSENT, 5'd0});
    foreach (dir[i]) send_request(dir[i]);

    // size 1: fills, then full
    write_size(6'd1);
    send_request('{OP_ADD, 32'd9, 64'd1, 64'd2, 1'b1, ST_OK, 5'd0});
    send_request('{OP_ADD, 32'd10, 64'd3, 64'd4, 1'b1, ST_FULL, 5'd0});
    send_request('{OP_SEARCH, 32'd9, '0, '0, 1'b1, ST_OK, 5'd0});
    // size 0 treated as 1, size above depth saturates
    write_size(6'd0);
    send_request('{OP_SEARCH, 32'd9, '0, '0, 1'b1, ST_OK, 5'd0});
    write_size(6'd63);
    send_request('{OP_ADD, 32'd31, '1, '0, 1'b1, ST_OK, 5'd31});
    send_request('{OP_SEARCH, 32'd9, '0, '0, 1'b1, ST_ABSENT, 5'd0});
    send_request('{OP_CLEAR, 32'd0, '0, '0, 1'b1, ST_OK, 5'd0});

    // random phases across sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_size(6'd32);
        1: write_size(6'd4);
        2: write_size(6'd17);
        3: write_size(6'd2);
        4: write_size(6'd9);
        default: write_size(6'd32);
      endcase
      if (ph == 2) begin
        // long receiver hold while requests keep coming
        hold_len = 400;
        hold_rsp = 1'b1;
      end
      for (int i = 0; i < 105; i++) random_request();
      if (ph == 3) begin
        req.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
    end

    req.valid <= 1'b0;
    waited = 0;
    while (pending_answers.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
